[rtl/lisr_pkg.sv]
// Package for the linear interpolation stereo resampler.
// Holds default sizes, field widths, register indexes and the sequencer state type.
// No dependencies.
package lisr_pkg;

  localparam int RING_SAMPLES_DEF   = 65536;
  localparam int MAX_FRAMES_DEF     = 64;
  localparam int MAX_SEEK_UNITS_DEF = 8;

  localparam int SAMPLE_W  = 16;
  localparam int FIDX_W    = 15;
  localparam int POS_IN_W  = 32;
  localparam int COUNT_W   = 7;
  localparam int REG_W     = 24;
  localparam int FRAC_W    = 16;
  // Clamped tempo magnitude stays below 2^23 for any seek limit up to 127.
  localparam int TMAG_W    = 23;
  // Shared multiplier operand width, signed.
  localparam int MUL_W     = 25;
  // Interpolation product: 16-bit fraction times 17-bit difference.
  localparam int PROD_W    = 33;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE = 1'd1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RIDX   = 11'b00000000010,
    S_RSTART = 11'b00000000100,
    S_MSTEP  = 11'b00000001000,
    S_RSTEP  = 11'b00000010000,
    S_NEG    = 11'b00000100000,
    S_RD     = 11'b00001000000,
    S_ML     = 11'b00010000000,
    S_MR     = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_WRAP   = 11'b10000000000
  } state_t;

endpackage

[rtl/linear_interp_stereo_resampler_unit.sv]
// Top level of the linear interpolation stereo resampler.
// Depends on lisr_pkg, lisr_alu and lisr_ring.
//
// Varispeed playback from a stereo ring of RING_SAMPLES/2 frames. A write
// transaction (tuser = 0) stores one left/right frame; its index wraps modulo
// the ring on the shared compare-subtract unit. A render transaction
// (tuser = 1) loads a Q16.16 start position in interleaved-sample units and
// emits up to MAX_FRAMES output frames. Setup reduces the start position
// modulo the ring, multiplies out the step, reduces the step modulo the ring
// and, for negative tempo, takes its complement. Each output frame then
// passes through five steps: ring read, left multiply, right multiply, output
// load, position wrap; the shared multiplier and subtractor make these steps
// run in turn. The output frame may sit in the output register while the
// next frame is computed; the block stalls in the output load step only when
// the previous frame has not been taken. The input side is ready only
// between items. Step = (2 * base_rate * |tempo|) >> 16, with tempo clamped
// to +/- MAX_SEEK_UNITS; negative tempo plays backward and interpolates
// toward the previous frame. Samples round half up. Config writes (cfg_we)
// are taken any cycle but must be made while idle.
module linear_interp_stereo_resampler_unit
  import lisr_pkg::*;
#(
  parameter int RING_SAMPLES   = RING_SAMPLES_DEF,
  parameter int MAX_FRAMES     = MAX_FRAMES_DEF,
  parameter int MAX_SEEK_UNITS = MAX_SEEK_UNITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input transactions
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata, low bit up: frame_index[14:0], left_in[30:15], right_in[46:31],
  // start_pos[78:47], frame_count[85:79], zero pad[87:86]
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // s_tuser: op (0 write frame, 1 render)
  input  logic                   s_tuser,
  // Output transactions
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata, low bit up: left_out[15:0], right_out[31:16]
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic                   m_tlast,
  // Configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  // Ring geometry and position modulus
  localparam int RF = RING_SAMPLES / 2;
  localparam int AW = $clog2(RF);
  localparam longint unsigned POS_MOD = longint'(2 * RF) << FRAC_W;
  localparam int PW = $clog2(POS_MOD);
  localparam int UW = (PW + 2 > 34) ? PW + 2 : 34;
  // Shift counts for the restoring reductions
  localparam int KST = (PW >= 33) ? 0 : 33 - PW;
  localparam int KW  = (AW >= 16) ? 0 : 16 - AW;
  localparam int KMAX = (KST > KW) ? KST : KW;
  localparam int KCW = $clog2(KMAX + 2);
  localparam logic signed [REG_W:0] LIM = (REG_W+1)'(MAX_SEEK_UNITS * 65536);

  // Configuration registers
  logic signed [REG_W-1:0] tempo;
  logic [REG_W-1:0]        base_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo     <= REG_W'(65536);
      base_rate <= REG_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMPO:     tempo     <= cfg_data;
        CFG_BASE_RATE: base_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input field unpack
  logic [FIDX_W-1:0]   in_fidx;
  logic [SAMPLE_W-1:0] in_left, in_right;
  logic [POS_IN_W-1:0] in_start;
  logic [COUNT_W-1:0]  in_count;

  assign in_fidx  = s_tdata[14:0];
  assign in_left  = s_tdata[30:15];
  assign in_right = s_tdata[46:31];
  assign in_start = s_tdata[78:47];
  assign in_count = s_tdata[85:79];

  // Sequencer and datapath registers
  state_t                 state, state_next;
  logic [UW-1:0]          red_v;
  logic [KCW-1:0]         red_k;
  logic [PW-1:0]          pos;
  logic [UW-1:0]          pos_sum;
  logic [UW-1:0]          step_add;
  logic [COUNT_W-1:0]     cnt;
  logic                   back;
  logic [TMAG_W-1:0]      tmag;
  logic [SAMPLE_W-1:0]    w_left, w_right;
  logic signed [PROD_W-1:0] prod_l, prod_r;
  logic                   out_valid, out_last;
  logic [OUT_DATA_W-1:0]  out_data;

  // Shared unit hookup
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [UW-1:0]             sub_a, sub_b, sub_d;
  logic                      sub_ge;
  logic [UW-1:0]             red_next;

  // Ring hookup
  logic                  ring_we, ring_re;
  logic [AW-1:0]         fa, fb;
  logic [2*SAMPLE_W-1:0] rd_a, rd_b;

  lisr_alu #(.W(UW)) u_alu (
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .mul_p  (mul_p),
    .sub_a  (sub_a),
    .sub_b  (sub_b),
    .sub_d  (sub_d),
    .sub_ge (sub_ge)
  );

  lisr_ring #(.FRAMES(RF)) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (red_next[AW-1:0]),
    .wdata   ({w_left, w_right}),
    .re      (ring_re),
    .raddr_a (fa),
    .raddr_b (fb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Frame pair for the current position: the even sample at or below it,
  // and its neighbor in the play direction, wrapping around the ring.
  assign fa = pos[PW-1:FRAC_W+1];
  always_comb begin
    if (back) begin
      fb = (fa == '0) ? AW'(RF - 1) : fa - AW'(1);
    end else begin
      fb = (fa == AW'(RF - 1)) ? '0 : fa + AW'(1);
    end
  end

  // Interpolation differences, one channel per multiply step
  logic signed [SAMPLE_W:0] diff_l, diff_r;
  assign diff_l = $signed({rd_b[31], rd_b[31:16]}) - $signed({rd_a[31], rd_a[31:16]});
  assign diff_r = $signed({rd_b[15], rd_b[15:0]}) - $signed({rd_a[15], rd_a[15:0]});

  // Multiplier operand select: step product during setup, else the lerp weight
  always_comb begin
    mul_a = $signed({1'b0, base_rate});
    mul_b = $signed({2'b0, tmag});
    if (state == S_ML) begin
      mul_a = $signed({9'd0, pos[FRAC_W-1:0]});
      mul_b = MUL_W'(diff_l);
    end else if (state == S_MR) begin
      mul_a = $signed({9'd0, pos[FRAC_W-1:0]});
      mul_b = MUL_W'(diff_r);
    end
  end

  // Compare-subtract operand select
  always_comb begin
    sub_a = red_v;
    sub_b = UW'(POS_MOD) << red_k;
    unique case (state)
      S_RIDX: sub_b = UW'(RF) << red_k;
      S_NEG: begin
        sub_a = UW'(POS_MOD);
        sub_b = step_add;
      end
      S_WRAP: begin
        sub_a = pos_sum;
        sub_b = UW'(POS_MOD);
      end
      default: ;
    endcase
  end

  assign red_next = sub_ge ? sub_d : sub_a;

  // Rounded outputs: a + ((frac*(b-a) + half) >> 16), low 16 bits
  logic signed [PROD_W:0] rnd_l, rnd_r;
  logic [SAMPLE_W-1:0]    res_l, res_r;
  assign rnd_l = {prod_l[PROD_W-1], prod_l} + (PROD_W+1)'(32768);
  assign rnd_r = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(32768);
  assign res_l = rd_a[31:16] + rnd_l[31:16];
  assign res_r = rd_a[15:0] + rnd_r[31:16];

  logic out_free, out_load, in_acc;
  assign out_free = !out_valid || m_tready;
  assign out_load = (state == S_OUT) && out_free;
  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign ring_we  = (state == S_RIDX) && (red_k == '0);
  assign ring_re  = (state == S_RD);

  // Tempo clamp and direction
  logic signed [REG_W:0] t_ext;
  logic                  back_in;
  logic [TMAG_W-1:0]     tmag_in;
  logic [REG_W:0]        t_neg;
  assign t_ext = {tempo[REG_W-1], tempo};
  assign t_neg = -t_ext;
  always_comb begin
    priority if (t_ext > LIM) begin
      back_in = 1'b0;
      tmag_in = TMAG_W'(LIM);
    end else if (t_ext < -LIM) begin
      back_in = 1'b1;
      tmag_in = TMAG_W'(LIM);
    end else if (t_ext < 0) begin
      back_in = 1'b1;
      tmag_in = t_neg[TMAG_W-1:0];
    end else begin
      back_in = 1'b0;
      tmag_in = t_ext[TMAG_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (in_acc) begin
          state_next = (s_tuser == OP_RENDER) ? S_RSTART : S_RIDX;
        end
      S_RIDX:
        if (red_k == '0) begin
          state_next = S_IDLE;
        end
      S_RSTART:
        if (red_k == '0) begin
          state_next = S_MSTEP;
        end
      S_MSTEP: state_next = S_RSTEP;
      S_RSTEP:
        if (red_k == '0) begin
          if (back) begin
            state_next = S_NEG;
          end else begin
            state_next = (cnt == '0) ? S_IDLE : S_RD;
          end
        end
      S_NEG: state_next = (cnt == '0) ? S_IDLE : S_RD;
      S_RD:  state_next = S_ML;
      S_ML:  state_next = S_MR;
      S_MR:  state_next = S_OUT;
      S_OUT:
        if (out_free) begin
          state_next = S_WRAP;
        end
      S_WRAP: state_next = (cnt == '0) ? S_IDLE : S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE:
          if (in_acc && s_tuser == OP_RENDER) begin
            // Saturate the frame count
            cnt <= (in_count > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : in_count;
          end
        S_RSTART:
          if (red_k == '0) begin
            pos <= red_next[PW-1:0];
          end
        S_OUT:
          if (out_free) begin
            cnt <= cnt - COUNT_W'(1);
          end
        S_WRAP: pos <= red_next[PW-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE:
        if (in_acc) begin
          w_left  <= in_left;
          w_right <= in_right;
          back    <= back_in;
          tmag    <= tmag_in;
          if (s_tuser == OP_RENDER) begin
            red_v <= UW'(in_start);
            red_k <= KCW'(KST);
          end else begin
            red_v <= UW'(in_fidx);
            red_k <= KCW'(KW);
          end
        end
      S_RIDX, S_RSTART: begin
        red_v <= red_next;
        red_k <= red_k - KCW'(1);
      end
      S_MSTEP: begin
        // (2 * base_rate * |tempo|) >> 16
        red_v <= UW'(mul_p[46:15]);
        red_k <= KCW'(KST);
      end
      S_RSTEP: begin
        red_v <= red_next;
        red_k <= red_k - KCW'(1);
        if (red_k == '0) begin
          step_add <= red_next;
        end
      end
      // Backward play adds the complement of the step
      S_NEG: step_add <= sub_d;
      S_ML:  prod_l <= mul_p[PROD_W-1:0];
      S_MR:  prod_r <= mul_p[PROD_W-1:0];
      S_OUT: pos_sum <= UW'(pos) + step_add;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {res_r, res_l};
      out_last <= (cnt == COUNT_W'(1));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_out_has_count: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> cnt != '0)
    else $error("output step with no frames left");

  a_last_ends_render: assert property (@(posedge clk) disable iff (rst)
    (out_load && cnt == COUNT_W'(1)) |=> ##1 state == S_IDLE)
    else $error("render did not end after its last frame");

  a_no_load_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !out_load)
    else $error("output overwritten while stalled");

  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WRAP |-> pos_sum < (UW'(POS_MOD) << 1))
    else $error("position sum out of range");
`endif

endmodule

[rtl/lisr_alu.sv]
// Shared arithmetic unit of the resampler: one signed multiplier and one
// compare-subtract. Depends on lisr_pkg.
module lisr_alu
  import lisr_pkg::*;
#(
  parameter int W = 34
) (
  input  logic signed [MUL_W-1:0]   mul_a,
  input  logic signed [MUL_W-1:0]   mul_b,
  output logic signed [2*MUL_W-1:0] mul_p,
  input  logic [W-1:0]              sub_a,
  input  logic [W-1:0]              sub_b,
  output logic [W-1:0]              sub_d,
  output logic                      sub_ge
);

  assign mul_p  = mul_a * mul_b;
  assign sub_ge = (sub_a >= sub_b);
  assign sub_d  = sub_a - sub_b;

endmodule

[rtl/lisr_ring.sv]
// Stereo frame ring: one write port, two registered read ports.
// Depends on lisr_pkg.
module lisr_ring
  import lisr_pkg::*;
#(
  parameter int FRAMES = RING_SAMPLES_DEF / 2,
  localparam int AW = $clog2(FRAMES)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [2*SAMPLE_W-1:0]   wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr_a,
  input  logic [AW-1:0]           raddr_b,
  output logic [2*SAMPLE_W-1:0]   rdata_a,
  output logic [2*SAMPLE_W-1:0]   rdata_b
);

  logic [2*SAMPLE_W-1:0] mem [FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
